### rtl/core/oal_pkg.sv
`default_nettype none

package oal_pkg;

    // fixed field widths of the request, result and config ports
    localparam int REQ_W     = 4;
    localparam int POS_W     = 8;
    localparam int VALUE_W   = 32;
    localparam int CAP_W     = 9;
    localparam int CNT_OUT_W = 9;

    // width used for every position and count compare, covers up to 8191 entries
    localparam int CTL_W = 13;

    // defaults of the top level parameters
    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_WORD_BITS   = 32;

    // capacity limit after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT_AT    = 4'd0,
        REQ_INSERT_FRONT = 4'd1,
        REQ_INSERT_BACK  = 4'd2,
        REQ_REMOVE_AT    = 4'd3,
        REQ_REMOVE_FRONT = 4'd4,
        REQ_REMOVE_BACK  = 4'd5,
        REQ_READ         = 4'd6,
        REQ_SEARCH       = 4'd7,
        REQ_REPLACE      = 4'd8
    } req_t;

    // what the row of cells does in one cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_REPLACE
    } cell_op_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_TREE
    } state_t;

    // control broadcast to every cell
    typedef struct packed {
        cell_op_t         op;
        logic [CTL_W-1:0] tpos;
        logic [CTL_W-1:0] count;
        logic [CTL_W-1:0] read_idx;
        logic             search;
    } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/core/oal_cell.sv
`default_nettype none

module oal_cell #(
    parameter int INDEX  = 0,
    parameter int DATA_W = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  oal_pkg::cell_ctl_t     ctl,
    input  wire  [DATA_W-1:0]      value,
    input  wire  [DATA_W-1:0]      left_word,
    input  wire  [DATA_W-1:0]      right_word,
    output logic [DATA_W-1:0]      word,
    output logic                   leaf_valid
);
    import oal_pkg::*;

    localparam logic [CTL_W-1:0] IDX = CTL_W'(INDEX);
    localparam logic [CTL_W-1:0] NXT = CTL_W'(INDEX + 1);

    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] word_next;

    // next word: hold, shift in from a neighbour, load or clear
    always_comb
    begin
        word_next = word_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (IDX == ctl.tpos)
                    word_next = value;
                else if (IDX > ctl.tpos && IDX <= ctl.count)
                    word_next = left_word;
            end
            CELL_REMOVE:
            begin
                if (NXT == ctl.count)
                    word_next = '0;
                else if (IDX >= ctl.tpos && NXT < ctl.count)
                    word_next = right_word;
            end
            CELL_REPLACE:
            begin
                if (IDX == ctl.tpos)
                    word_next = value;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    // entry register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else
            word_reg <= word_next;
    end

    // leaf of the select tree: match on search, position hit on read
    always_comb
    begin
        if (ctl.search)
            leaf_valid = (word_reg == value) && (IDX < ctl.count);
        else
            leaf_valid = (IDX == ctl.read_idx);
    end

    assign word = word_reg;

endmodule

`default_nettype wire

### rtl/core/oal_tree.sv
`default_nettype none

module oal_tree #(
    parameter int LEVELS = 8,
    parameter int DATA_W = 32
) (
    input  wire                    clk,
    input  wire                    leaf_valid [2**LEVELS],
    input  wire  [DATA_W-1:0]      leaf_word  [2**LEVELS],
    output logic                   root_valid,
    output logic [LEVELS-1:0]      root_idx,
    output logic [DATA_W-1:0]      root_word
);
    import oal_pkg::*;

    localparam int LEAVES = 2**LEVELS;

    // heap of nodes, node k has children 2k and 2k+1, leaves sit above LEAVES-1
    logic              node_valid_reg [1:LEAVES-1];
    logic [LEVELS-1:0] node_idx_reg   [1:LEAVES-1];
    logic [DATA_W-1:0] node_word_reg  [1:LEAVES-1];

    for (genvar k = 1; k < LEAVES; k++)
    begin : g_node
        logic              l_valid;
        logic              r_valid;
        logic [LEVELS-1:0] l_idx;
        logic [LEVELS-1:0] r_idx;
        logic [DATA_W-1:0] l_word;
        logic [DATA_W-1:0] r_word;

        if (2 * k < LEAVES)
        begin : g_inner
            assign l_valid = node_valid_reg[2*k];
            assign l_idx   = node_idx_reg[2*k];
            assign l_word  = node_word_reg[2*k];
            assign r_valid = node_valid_reg[2*k+1];
            assign r_idx   = node_idx_reg[2*k+1];
            assign r_word  = node_word_reg[2*k+1];
        end
        else
        begin : g_bottom
            assign l_valid = leaf_valid[2*k-LEAVES];
            assign l_idx   = LEVELS'(2*k-LEAVES);
            assign l_word  = leaf_word[2*k-LEAVES];
            assign r_valid = leaf_valid[2*k+1-LEAVES];
            assign r_idx   = LEVELS'(2*k+1-LEAVES);
            assign r_word  = leaf_word[2*k+1-LEAVES];
        end

        // lower position wins
        always_ff @(posedge clk)
        begin
            node_valid_reg[k] <= l_valid | r_valid;
            if (l_valid)
            begin
                node_idx_reg[k]  <= l_idx;
                node_word_reg[k] <= l_word;
            end
            else
            begin
                node_idx_reg[k]  <= r_idx;
                node_word_reg[k] <= r_word;
            end
        end
    end

    assign root_valid = node_valid_reg[1];
    assign root_idx   = node_idx_reg[1];
    assign root_word  = node_word_reg[1];

endmodule

`default_nettype wire

### rtl/core/ordered_array_list_engine.sv
// channel   | handshake                   | payload
// ----------+-----------------------------+---------------------------------------------
// request   | start in, busy out          | req_type, position, value
// result    | done out (one-cycle strobe) | ok, read_data, found_position, entry_count,
//           |                             | is_empty, is_full
// config    | cfg_valid in, cfg_ready out | cfg_data (capacity limit)
//
// inserts, removes, replaces and unknown codes: done in the next cycle, busy stays low
// read and search: busy is high until done, which comes once the result has passed the
//   registered select tree of depth LEVELS = clog2(MAX_ENTRIES)
// a new request is taken in the cycle that done is high
// reset clears every cell, the count and the state, and sets the capacity limit to 256
// results cannot be stalled; cfg_ready is always high
`default_nettype none

module ordered_array_list_engine #(
    parameter int MAX_ENTRIES = oal_pkg::DEF_MAX_ENTRIES,
    parameter int WORD_BITS   = oal_pkg::DEF_WORD_BITS
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire  [oal_pkg::REQ_W-1:0]      req_type,
    input  wire  [oal_pkg::POS_W-1:0]      position,
    input  wire  [oal_pkg::VALUE_W-1:0]    value,
    output logic                           done,
    output logic                           ok,
    output logic [oal_pkg::VALUE_W-1:0]    read_data,
    output logic [oal_pkg::CNT_OUT_W-1:0]  found_position,
    output logic [oal_pkg::CNT_OUT_W-1:0]  entry_count,
    output logic                           is_empty,
    output logic                           is_full,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [oal_pkg::CAP_W-1:0]      cfg_data
);
    import oal_pkg::*;

    localparam int LEVELS = $clog2(MAX_ENTRIES);
    localparam int LEAVES = 2**LEVELS;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;
    localparam int WAIT_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [CTL_W-1:0] MAX_C = CTL_W'(MAX_ENTRIES);

    state_t                 state_reg;
    state_t                 state_next;
    logic [WAIT_W-1:0]      wait_reg;
    logic [WAIT_W-1:0]      wait_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CAP_W-1:0]       cap_reg;
    logic                   search_reg;
    logic                   search_next;
    logic                   pend_ok_reg;
    logic                   pend_ok_next;
    logic                   done_reg;
    logic                   done_next;
    logic                   ok_reg;
    logic                   ok_next;
    logic [VALUE_W-1:0]     rdata_reg;
    logic [VALUE_W-1:0]     rdata_next;
    logic [CNT_OUT_W-1:0]   found_reg;
    logic [CNT_OUT_W-1:0]   found_next;
    logic [CNT_OUT_W-1:0]   count_out_reg;
    logic [CNT_OUT_W-1:0]   count_out_next;
    logic                   empty_reg;
    logic                   empty_next;
    logic                   full_reg;
    logic                   full_next;

    req_t                   req;
    logic                   accept;
    logic [CTL_W-1:0]       cnt_w;
    logic [CTL_W-1:0]       pos_w;
    logic [CTL_W-1:0]       lim_w;
    logic [CTL_W-1:0]       ins_pos;
    logic [CTL_W-1:0]       rem_pos;
    logic [CTL_W-1:0]       read_idx;
    logic                   ins_ok;
    logic                   rem_ok;
    logic                   rep_ok;
    logic                   read_ok;
    logic [DATA_W-1:0]      value_w;
    cell_ctl_t              ctl;

    logic [DATA_W-1:0]      cell_word  [MAX_ENTRIES];
    logic                   leaf_valid [LEAVES];
    logic [DATA_W-1:0]      leaf_word  [LEAVES];
    logic                   root_valid;
    logic [LEVELS-1:0]      root_idx;
    logic [DATA_W-1:0]      root_word;

    // request decode and bound checks
    assign req     = req_t'(req_type);
    assign busy    = (state_reg == ST_TREE);
    assign accept  = start && !busy;
    assign cnt_w   = CTL_W'(count_reg);
    assign pos_w   = CTL_W'(position);
    assign lim_w   = (CTL_W'(cap_reg) > MAX_C) ? MAX_C : CTL_W'(cap_reg);
    assign value_w = value[DATA_W-1:0];

    assign ins_pos = (req == REQ_INSERT_AT)    ? pos_w :
                     (req == REQ_INSERT_FRONT) ? '0 : cnt_w;
    assign rem_pos = (req == REQ_REMOVE_AT)    ? pos_w :
                     (req == REQ_REMOVE_FRONT) ? '0 : cnt_w - CTL_W'(1);

    assign ins_ok  = (cnt_w < lim_w) && (ins_pos <= cnt_w) && (cnt_w < MAX_C);
    assign rem_ok  = (cnt_w != '0) && (rem_pos < cnt_w);
    assign rep_ok  = (pos_w < cnt_w);
    assign read_ok = (pos_w < cnt_w);

    assign read_idx = (cnt_w == '0)   ? '0 :
                      (pos_w >= cnt_w) ? cnt_w - CTL_W'(1) : pos_w;

    // next state, cell control and result values
    always_comb
    begin
        state_next   = state_reg;
        wait_next    = wait_reg;
        count_next   = count_reg;
        search_next  = search_reg;
        pend_ok_next = pend_ok_reg;
        done_next    = 1'b0;
        ok_next      = 1'b0;
        rdata_next   = '0;
        found_next   = '0;

        ctl.op       = CELL_HOLD;
        ctl.tpos     = '0;
        ctl.count    = cnt_w;
        ctl.read_idx = read_idx;
        ctl.search   = (req == REQ_SEARCH);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req) inside
                        REQ_INSERT_AT, REQ_INSERT_FRONT, REQ_INSERT_BACK:
                        begin
                            done_next = 1'b1;
                            if (ins_ok)
                            begin
                                ctl.op     = CELL_INSERT;
                                ctl.tpos   = ins_pos;
                                count_next = count_reg + CNT_W'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        REQ_REMOVE_AT, REQ_REMOVE_FRONT, REQ_REMOVE_BACK:
                        begin
                            done_next = 1'b1;
                            if (rem_ok)
                            begin
                                ctl.op     = CELL_REMOVE;
                                ctl.tpos   = rem_pos;
                                count_next = count_reg - CNT_W'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        REQ_READ:
                        begin
                            state_next   = ST_TREE;
                            wait_next    = WAIT_W'(LEVELS - 1);
                            search_next  = 1'b0;
                            pend_ok_next = read_ok;
                        end
                        REQ_SEARCH:
                        begin
                            state_next   = ST_TREE;
                            wait_next    = WAIT_W'(LEVELS - 1);
                            search_next  = 1'b1;
                            pend_ok_next = 1'b0;
                        end
                        REQ_REPLACE:
                        begin
                            done_next = 1'b1;
                            if (rep_ok)
                            begin
                                ctl.op   = CELL_REPLACE;
                                ctl.tpos = pos_w;
                                ok_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_TREE:
            begin
                if (wait_reg == '0)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (search_reg)
                    begin
                        ok_next    = root_valid;
                        found_next = root_valid ? CNT_OUT_W'(root_idx)
                                                : CNT_OUT_W'(count_reg);
                    end
                    else
                    begin
                        ok_next    = pend_ok_reg;
                        rdata_next = VALUE_W'(root_word);
                    end
                end
                else
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        count_out_next = CNT_OUT_W'(count_next);
        empty_next     = (count_next == '0);
        full_next      = (CTL_W'(count_next) >= lim_w);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wait_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    // result and pending request registers
    always_ff @(posedge clk)
    begin
        search_reg    <= search_next;
        pend_ok_reg   <= pend_ok_next;
        ok_reg        <= ok_next;
        rdata_reg     <= rdata_next;
        found_reg     <= found_next;
        count_out_reg <= count_out_next;
        empty_reg     <= empty_next;
        full_reg      <= full_next;
    end

    // row of entry cells, padded leaves never win
    for (genvar j = 0; j < LEAVES; j++)
    begin : g_cell
        if (j < MAX_ENTRIES)
        begin : g_used
            logic [DATA_W-1:0] left_in;
            logic [DATA_W-1:0] right_in;

            if (j == 0)
            begin : g_first
                assign left_in = '0;
            end
            else
            begin : g_mid_l
                assign left_in = cell_word[j-1];
            end

            if (j == MAX_ENTRIES - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_mid_r
                assign right_in = cell_word[j+1];
            end

            oal_cell #(
                .INDEX  (j),
                .DATA_W (DATA_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .value      (value_w),
                .left_word  (left_in),
                .right_word (right_in),
                .word       (cell_word[j]),
                .leaf_valid (leaf_valid[j])
            );

            assign leaf_word[j] = cell_word[j];
        end
        else
        begin : g_pad
            assign leaf_valid[j] = 1'b0;
            assign leaf_word[j]  = '0;
        end
    end

    // registered select tree for read and search
    oal_tree #(
        .LEVELS (LEVELS),
        .DATA_W (DATA_W)
    ) u_tree (
        .clk        (clk),
        .leaf_valid (leaf_valid),
        .leaf_word  (leaf_word),
        .root_valid (root_valid),
        .root_idx   (root_idx),
        .root_word  (root_word)
    );

    // outputs
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign read_data      = rdata_reg;
    assign found_position = found_reg;
    assign entry_count    = count_out_reg;
    assign is_empty       = empty_reg;
    assign is_full        = full_reg;

    // checks
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(done && busy))
        else $error("result strobe while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type != REQ_READ && req_type != REQ_SEARCH) |=> done)
        else $error("missing result one cycle after beat");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) ||
        (count_reg == $past(count_reg) + CNT_W'(1)) ||
        (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

endmodule

`default_nettype wire

### tb/ordered_array_list_engine_test.sv
`timescale 1ns / 100ps

module ordered_array_list_engine_test;

    import oal_pkg::*;

    localparam int DEPTH = DEF_MAX_ENTRIES;

    // status reported with every result beat
    typedef struct packed {
        logic                 ok;
        logic [VALUE_W-1:0]   rdata;
        logic [CNT_OUT_W-1:0] fpos;
        logic [CNT_OUT_W-1:0] ecnt;
        logic                 empty;
        logic                 full;
    } list_status_t;

    typedef enum {
        MIX,
        GROW,
        SHRINK
    } phase_mode_t;

    // shadow copy of the list and the queue of status beats still owed
    class list_tracker;
        logic [VALUE_W-1:0] slot [DEPTH];
        int unsigned        cnt;
        int unsigned        limit_reg;
        int unsigned        faults;
        list_status_t       awaited [$];

        function new();
            foreach (slot[i])
                slot[i] = '0;
            cnt       = 0;
            limit_reg = CAP_RESET;
            faults    = 0;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void set_limit(logic [CAP_W-1:0] lim);
            limit_reg = lim;
        endfunction

        // limit saturates at the store depth
        function bit list_full();
            int unsigned eff;
            eff = (limit_reg > DEPTH) ? DEPTH : limit_reg;
            return cnt >= eff;
        endfunction

        function bit insert_word(int unsigned pos, logic [VALUE_W-1:0] v);
            if (list_full() || pos > cnt || cnt >= DEPTH)
                return 1'b0;
            for (int unsigned i = cnt; i > pos; i--)
                slot[i] = slot[i-1];
            slot[pos] = v;
            cnt++;
            return 1'b1;
        endfunction

        // later entries move down, freed slot is cleared
        function bit remove_word(int unsigned pos);
            if (cnt == 0 || pos >= cnt)
                return 1'b0;
            for (int unsigned i = pos; i + 1 < cnt; i++)
                slot[i] = slot[i+1];
            slot[cnt-1] = '0;
            cnt--;
            return 1'b1;
        endfunction

        // apply one accepted request beat and note the status it must give
        function void log_request(logic [REQ_W-1:0] r, logic [POS_W-1:0] p,
                                  logic [VALUE_W-1:0] v);
            list_status_t s;
            s = '0;
            case (r)
                REQ_INSERT_AT:    s.ok = insert_word(p, v);
                REQ_INSERT_FRONT: s.ok = insert_word(0, v);
                REQ_INSERT_BACK:  s.ok = insert_word(cnt, v);
                REQ_REMOVE_AT:    s.ok = remove_word(p);
                REQ_REMOVE_FRONT: s.ok = remove_word(0);
                REQ_REMOVE_BACK:
                begin
                    if (cnt != 0)
                        s.ok = remove_word(cnt - 1);
                end
                REQ_READ:
                begin
                    if (cnt == 0)
                        s.rdata = slot[0];
                    else if (p >= cnt)
                        s.rdata = slot[cnt-1];
                    else
                    begin
                        s.rdata = slot[p];
                        s.ok    = 1'b1;
                    end
                end
                REQ_SEARCH:
                begin
                    s.fpos = CNT_OUT_W'(cnt);
                    for (int unsigned i = 0; i < cnt; i++)
                    begin
                        if (slot[i] == v)
                        begin
                            s.fpos = CNT_OUT_W'(i);
                            s.ok   = 1'b1;
                            break;
                        end
                    end
                end
                REQ_REPLACE:
                begin
                    if (p < cnt)
                    begin
                        slot[p] = v;
                        s.ok    = 1'b1;
                    end
                end
                default: ;
            endcase
            s.ecnt  = CNT_OUT_W'(cnt);
            s.empty = (cnt == 0);
            s.full  = list_full();
            awaited.push_back(s);
        endfunction

        function void flag_field(string name, logic [VALUE_W-1:0] want,
                                 logic [VALUE_W-1:0] got);
            if (want !== got)
            begin
                faults++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // compare one result beat with the oldest owed status
        function void check_response(logic ok_b, logic [VALUE_W-1:0] rd,
                                     logic [CNT_OUT_W-1:0] fp, logic [CNT_OUT_W-1:0] ec,
                                     logic em, logic fu);
            list_status_t want;
            if (awaited.size() == 0)
            begin
                faults++;
                $display("%0t: result beat with no request waiting, expected none actual count %0h",
                         $time, ec);
                return;
            end
            want = awaited.pop_front();
            flag_field("ok", VALUE_W'(want.ok), VALUE_W'(ok_b));
            flag_field("read_data", want.rdata, rd);
            flag_field("found_position", VALUE_W'(want.fpos), VALUE_W'(fp));
            flag_field("entry_count", VALUE_W'(want.ecnt), VALUE_W'(ec));
            flag_field("is_empty", VALUE_W'(want.empty), VALUE_W'(em));
            flag_field("is_full", VALUE_W'(want.full), VALUE_W'(fu));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic [REQ_W-1:0]      req_type  = '0;
    logic [POS_W-1:0]      position  = '0;
    logic [VALUE_W-1:0]    value     = '0;
    logic                  cfg_valid = 1'b0;
    logic [CAP_W-1:0]      cfg_data  = '0;
    logic                  busy;
    logic                  done;
    logic                  ok;
    logic [VALUE_W-1:0]    read_data;
    logic [CNT_OUT_W-1:0]  found_position;
    logic [CNT_OUT_W-1:0]  entry_count;
    logic                  is_empty;
    logic                  is_full;
    logic                  cfg_ready;

    list_tracker tracker = new();

    ordered_array_list_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .position       (position),
        .value          (value),
        .done           (done),
        .ok             (ok),
        .read_data      (read_data),
        .found_position (found_position),
        .entry_count    (entry_count),
        .is_empty       (is_empty),
        .is_full        (is_full),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // watch all three channels at each rising edge
    always @(posedge clk)
    begin
        if (done)
            tracker.check_response(ok, read_data, found_position, entry_count,
                                   is_empty, is_full);
        if (start && !busy)
            tracker.log_request(req_type, position, value);
        if (cfg_valid && cfg_ready)
            tracker.set_limit(cfg_data);
    end

    // hold one request beat until the block takes it; start stays high
    task automatic send_request(logic [REQ_W-1:0] r, logic [POS_W-1:0] p,
                                logic [VALUE_W-1:0] v);
        start    <= 1'b1;
        req_type <= r;
        position <= p;
        value    <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // stop sending and wait for every owed result beat
    task automatic drain();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(logic [CAP_W-1:0] lim);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // request mix leans towards filling or emptying the list in GROW and SHRINK, MIX is about even
    function automatic logic [REQ_W-1:0] pick_req(phase_mode_t mode);
        int r;
        int ins;
        int rem;
        ins = (mode == GROW) ? 80 : (mode == SHRINK) ? 8 : 35;
        rem = (mode == SHRINK) ? 75 : (mode == GROW) ? 8 : 30;
        r   = $urandom_range(0, 99);
        if (r < 3)
            return REQ_W'($urandom_range(9, 15));
        if (r < 3 + ins)
        begin
            case ($urandom_range(0, 2))
                0:       return REQ_INSERT_AT;
                1:       return REQ_INSERT_FRONT;
                default: return REQ_INSERT_BACK;
            endcase
        end
        if (r < 3 + ins + rem)
        begin
            case ($urandom_range(0, 2))
                0:       return REQ_REMOVE_AT;
                1:       return REQ_REMOVE_FRONT;
                default: return REQ_REMOVE_BACK;
            endcase
        end
        case ($urandom_range(0, 2))
            0:       return REQ_READ;
            1:       return REQ_SEARCH;
            default: return REQ_REPLACE;
        endcase
    endfunction

    // mostly inside the list, some at its edges, some anywhere
    function automatic logic [POS_W-1:0] pick_position();
        int unsigned top;
        top = (tracker.cnt > 255) ? 255 : tracker.cnt;
        case ($urandom_range(0, 9))
            0, 1:    return POS_W'($urandom_range(0, 255));
            2:       return POS_W'(top);
            3:       return POS_W'((top > 0) ? top - 1 : 0);
            default: return POS_W'($urandom_range(0, top));
        endcase
    endfunction

    // small pool gives duplicates and search hits
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4:    return $urandom_range(0, 7);
            default:    return $urandom;
        endcase
    endfunction

    // random bursts with random gaps between them
    task automatic run_phase(phase_mode_t mode, int items);
        int               burst;
        int               gap;
        logic [REQ_W-1:0] r;
        logic [POS_W-1:0] p;
        logic [VALUE_W-1:0] v;
        burst = 0;
        repeat (items)
        begin
            if (burst == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    start    <= 1'b0;
                    req_type <= REQ_W'($urandom);
                    position <= POS_W'($urandom);
                    value    <= $urandom;
                    repeat (gap) @(posedge clk);
                end
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 12);
            end
            r = pick_req(mode);
            p = pick_position();
            v = pick_value();
            if (r == REQ_SEARCH && tracker.cnt != 0 && $urandom_range(0, 1) == 1)
                v = tracker.slot[$urandom_range(0, tracker.cnt - 1)];
            send_request(r, p, v);
            burst--;
        end
    endtask

    // reset, directed requests, then random phases over several limits
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: a read, removes, replace, search and a bad insert
        send_request(REQ_READ, 8'd0, 32'h0);
        send_request(REQ_REMOVE_FRONT, 8'd0, 32'h0);
        send_request(REQ_REMOVE_BACK, 8'd0, 32'h0);
        send_request(REQ_REMOVE_AT, 8'd0, 32'h0);
        send_request(REQ_REPLACE, 8'd0, 32'hDEADBEEF);
        send_request(REQ_SEARCH, 8'd0, 32'h0);
        send_request(REQ_INSERT_AT, 8'd1, 32'h1);
        // build a short list
        send_request(REQ_INSERT_BACK, 8'd0, 32'hFFFFFFFF);
        send_request(REQ_INSERT_FRONT, 8'd0, 32'h0);
        send_request(REQ_INSERT_AT, 8'd1, 32'hA5A5A5A5);
        send_request(REQ_INSERT_AT, 8'd4, 32'h2);
        send_request(REQ_INSERT_AT, 8'd3, 32'h5A5A5A5A);
        // reads in and out of range, search hit and miss, replaces and removes in and out of range
        send_request(REQ_READ, 8'd0, 32'h0);
        send_request(REQ_READ, 8'd3, 32'h0);
        send_request(REQ_READ, 8'd255, 32'h0);
        send_request(REQ_SEARCH, 8'd0, 32'hFFFFFFFF);
        send_request(REQ_SEARCH, 8'd0, 32'h12345678);
        send_request(REQ_REPLACE, 8'd2, 32'h12345678);
        send_request(REQ_REPLACE, 8'd255, 32'h1);
        send_request(REQ_REMOVE_AT, 8'd255, 32'h0);
        send_request(REQ_REMOVE_AT, 8'd1, 32'h0);
        // unknown codes change nothing
        send_request(4'd9, 8'd255, 32'hFFFFFFFF);
        send_request(4'd15, 8'd0, 32'h0);
        send_request(REQ_REMOVE_BACK, 8'd0, 32'h0);
        send_request(REQ_REMOVE_FRONT, 8'd0, 32'h0);
        drain();

        write_limit(9'd256);
        run_phase(MIX, 150);
        drain();
        // limit above the depth saturates, list fills up
        write_limit(9'd511);
        run_phase(GROW, 400);
        drain();
        // limit below the count blocks inserts
        write_limit(9'd100);
        run_phase(MIX, 100);
        drain();
        write_limit(9'd256);
        run_phase(SHRINK, 350);
        drain();
        write_limit(9'd0);
        run_phase(MIX, 60);
        drain();
        write_limit(9'd1);
        run_phase(MIX, 80);
        drain();
        write_limit(9'd7);
        run_phase(MIX, 150);
        drain();
        write_limit(9'd256);
        run_phase(MIX, 160);
        drain();

        // room for a late or spurious result beat
        repeat (20) @(posedge clk);
        if (tracker.faults == 0 && tracker.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/core/oal_pkg.sv
rtl/core/oal_cell.sv
rtl/core/oal_tree.sv
rtl/core/ordered_array_list_engine.sv
tb/ordered_array_list_engine_test.sv
